// ----- rtl/core/lqi_pkg.sv -----
// ----------------------------------------------------------------------------
// lqi_pkg
// Shared types, constants and the linear step function of the quadrilinear interpolation lookup table.
// ----------------------------------------------------------------------------
package lqi_pkg;

  localparam int unsigned DPointsDef   = 32;
  localparam int unsigned PhiPointsDef = 32;
  localparam int unsigned ZPointsDef   = 16;
  localparam int unsigned RcPointsDef  = 16;
  localparam int unsigned FracBits     = 8;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned ExtBits      = ValueBits + 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } lqi_op_e;

  typedef struct packed {
    lqi_op_e               operation;
    logic [4:0]            load_d_index;
    logic [4:0]            load_phi_index;
    logic [3:0]            load_z_index;
    logic [3:0]            load_rc_index;
    logic signed [15:0]    load_value;
    logic [12:0]           d_pos;
    logic [12:0]           phi_pos;
    logic [11:0]           z_pos;
    logic [11:0]           rc_pos;
  } lqi_in_t;

  typedef struct packed {
    logic signed [15:0] interp_value;
    logic               clamped;
  } lqi_out_t;

  // One linear step: round-to-nearest, ties toward plus infinity, floor shift.
  // Inputs stay within the table range, so ExtBits holds every intermediate.
  function automatic logic signed [ExtBits-1:0] lqi_lerp(
    input logic signed [ExtBits-1:0] a,
    input logic signed [ExtBits-1:0] b,
    input logic [FracBits-1:0]       f
  );
    logic signed [ExtBits+FracBits+2:0] acc;
    begin
      acc = ($signed({{(FracBits+3){a[ExtBits-1]}}, a}) <<< FracBits)
          + $signed({1'b0, f}) * ($signed(b) - $signed(a))
          + $signed((ExtBits+FracBits+3)'(1) <<< (FracBits-1));
      lqi_lerp = ExtBits'(acc >>> FracBits);
    end
  endfunction

endpackage

// ----- rtl/core/lut_quadrilinear_interp_core.sv -----
// A query's result strobes on done_o after the bank read and the phi, d, z and rc steps.
// Throughput: one item per cycle; busy is always low and results cannot be held off.
// A load is written into its parity bank at the edge that accepts it.
// The table content is undefined after reset; reset clears only valid bits.
// Pipeline: split, bank read, phi step, d step, z step, rc step and clamp.
// ----------------------------------------------------------------------------
// lut_quadrilinear_interp_core
// Four-dimensional table with pipelined quadrilinear interpolation.
// ----------------------------------------------------------------------------
module lut_quadrilinear_interp_core
  import lqi_pkg::*;
#(
  parameter int unsigned DPoints   = DPointsDef,
  parameter int unsigned PhiPoints = PhiPointsDef,
  parameter int unsigned ZPoints   = ZPointsDef,
  parameter int unsigned RcPoints  = RcPointsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lqi_in_t  item_i,
  output logic     done_o,
  output lqi_out_t result_o
);

  assign busy = 1'b0;

  // Stage 0: split coordinates.
  function automatic logic [FracBits+5:0] split(input logic [12:0] pos,
                                                input int unsigned pts);
    logic [12:0] ip;
    begin
      ip = pos >> FracBits;
      if (32'(ip) >= pts - 1) begin
        split = {1'b0, 5'(pts - 1), FracBits'(0)};
        if (32'(pos) > ((pts - 1) << FracBits)) split[FracBits+5] = 1'b1;
      end else begin
        split = {1'b0, ip[4:0], pos[FracBits-1:0]};
      end
    end
  endfunction

  logic [FracBits+5:0] sd, sp, sz, sr;
  assign sd = split(item_i.d_pos, DPoints);
  assign sp = split(item_i.phi_pos, PhiPoints);
  assign sz = split({1'b0, item_i.z_pos}, ZPoints);
  assign sr = split({1'b0, item_i.rc_pos}, RcPoints);

  logic [4:0] dl, pl, dh, ph;
  logic [3:0] zl, rl, zh, rh;
  assign dl = sd[FracBits+4:FracBits];
  assign pl = sp[FracBits+4:FracBits];
  assign zl = sz[FracBits+3:FracBits];
  assign rl = sr[FracBits+3:FracBits];
  assign dh = (32'(dl) == DPoints - 1)   ? dl : dl + 5'd1;
  assign ph = (32'(pl) == PhiPoints - 1) ? pl : pl + 5'd1;
  assign zh = (32'(zl) == ZPoints - 1)   ? zl : zl + 4'd1;
  assign rh = (32'(rl) == RcPoints - 1)  ? rl : rl + 4'd1;

  logic load_ok;
  assign load_ok = start && (item_i.operation == OP_LOAD)
    && (32'(item_i.load_d_index) < DPoints) && (32'(item_i.load_phi_index) < PhiPoints)
    && (32'(item_i.load_z_index) < ZPoints) && (32'(item_i.load_rc_index) < RcPoints);

  logic [ValueBits-1:0] corner [16];

  lqi_bank_array #(
    .DPoints (DPoints), .PhiPoints (PhiPoints),
    .ZPoints (ZPoints), .RcPoints (RcPoints)
  ) u_banks (
    .clk_i    (clk_i),
    .we_i     (load_ok),
    .wd_i     (item_i.load_d_index),
    .wp_i     (item_i.load_phi_index),
    .wz_i     (item_i.load_z_index),
    .wr_i     (item_i.load_rc_index),
    .wdata_i  (item_i.load_value),
    .dl_i (dl), .pl_i (pl), .zl_i (zl), .rl_i (rl),
    .dh_i (dh), .ph_i (ph), .zh_i (zh), .rh_i (rh),
    .corner_o (corner)
  );

  // Valid, clamp flags and fractions travel with the data.
  logic [4:0] vld_q;
  logic [4:0] clp_q;
  logic [FracBits-1:0] fp_q, fd_q [2], fz_q [3], fr_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start && (item_i.operation == OP_QUERY)};
    end
  end

  always_ff @(posedge clk_i) begin
    clp_q <= {clp_q[3:0], sd[FracBits+5] | sp[FracBits+5] | sz[FracBits+5] | sr[FracBits+5]};
    fp_q  <= sp[FracBits-1:0];
    fd_q[0] <= sd[FracBits-1:0]; fd_q[1] <= fd_q[0];
    fz_q[0] <= sz[FracBits-1:0]; fz_q[1] <= fz_q[0]; fz_q[2] <= fz_q[1];
    fr_q[0] <= sr[FracBits-1:0]; fr_q[1] <= fr_q[0];
    fr_q[2] <= fr_q[1]; fr_q[3] <= fr_q[2];
  end

  logic signed [ExtBits-1:0] s1_q [8], s2_q [4], s3_q [2], s4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      s1_q[i] <= lqi_lerp(ExtBits'($signed(corner[2*i])),
                          ExtBits'($signed(corner[2*i+1])), fp_q);
    end
    for (int i = 0; i < 4; i++) begin
      s2_q[i] <= lqi_lerp(s1_q[2*i], s1_q[2*i+1], fd_q[1]);
    end
    for (int i = 0; i < 2; i++) begin
      s3_q[i] <= lqi_lerp(s2_q[2*i], s2_q[2*i+1], fz_q[2]);
    end
    s4_q <= lqi_lerp(s3_q[0], s3_q[1], fr_q[3]);
  end

  localparam logic signed [ExtBits-1:0] HiLim = ExtBits'((1 << (ValueBits-1)) - 1);
  localparam logic signed [ExtBits-1:0] LoLim = -ExtBits'(1 << (ValueBits-1));

  assign done_o = vld_q[4];
  assign result_o.clamped = clp_q[4];
  assign result_o.interp_value = (s4_q > HiLim) ? ValueBits'(HiLim)
                               : (s4_q < LoLim) ? ValueBits'(LoLim)
                               : ValueBits'(s4_q);

`ifndef ASSERT_OFF
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && item_i.operation == OP_QUERY, 5))
    else $error("result without query");
  a_query_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && item_i.operation == OP_QUERY) |-> ##5 done_o)
    else $error("query lost");
`endif

endmodule

// ----- rtl/core/lqi_ram.sv -----
// ----------------------------------------------------------------------------
// lqi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lqi_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lqi_bank_array.sv -----
// ----------------------------------------------------------------------------
// lqi_bank_array
// Sixteen RAM banks selected by the parity of the four grid indices, so all
// corners of one query cell are read in parallel.
// ----------------------------------------------------------------------------
module lqi_bank_array
  import lqi_pkg::*;
#(
  parameter int unsigned DPoints   = DPointsDef,
  parameter int unsigned PhiPoints = PhiPointsDef,
  parameter int unsigned ZPoints   = ZPointsDef,
  parameter int unsigned RcPoints  = RcPointsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [4:0]           wd_i,
  input  logic [4:0]           wp_i,
  input  logic [3:0]           wz_i,
  input  logic [3:0]           wr_i,
  input  logic [ValueBits-1:0] wdata_i,
  input  logic [4:0]           dl_i,
  input  logic [4:0]           pl_i,
  input  logic [3:0]           zl_i,
  input  logic [3:0]           rl_i,
  input  logic [4:0]           dh_i,
  input  logic [4:0]           ph_i,
  input  logic [3:0]           zh_i,
  input  logic [3:0]           rh_i,
  output logic [ValueBits-1:0] corner_o [16]
);

  localparam int unsigned DH = (DPoints + 1) / 2;
  localparam int unsigned PH = (PhiPoints + 1) / 2;
  localparam int unsigned ZH = (ZPoints + 1) / 2;
  localparam int unsigned RH = (RcPoints + 1) / 2;
  localparam int unsigned BankDepth = DH * PH * ZH * RH;
  localparam int unsigned AW = $clog2(BankDepth);

  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr_v [16];
  logic [3:0]           par_v [16];
  logic [ValueBits-1:0] rdata [16];

  assign waddr = AW'((((32'(wr_i >> 1) * ZH + 32'(wz_i >> 1)) * DH
               + 32'(wd_i >> 1)) * PH) + 32'(wp_i >> 1));

  // Corner k: bit0 phi high, bit1 d high, bit2 z high, bit3 rc high.
  for (genvar k = 0; k < 16; k++) begin : g_corner
    logic [4:0] cd, cp;
    logic [3:0] cz, cr;
    logic [3:0] par_q;
    assign cp = ((k & 1) != 0) ? ph_i : pl_i;
    assign cd = ((k & 2) != 0) ? dh_i : dl_i;
    assign cz = ((k & 4) != 0) ? zh_i : zl_i;
    assign cr = ((k & 8) != 0) ? rh_i : rl_i;
    // Bank b holds entries whose index parities match b.
    assign raddr_v[k] = AW'((((32'(cr >> 1) * ZH + 32'(cz >> 1)) * DH
                      + 32'(cd >> 1)) * PH) + 32'(cp >> 1));
    assign par_v[k] = {cr[0], cz[0], cd[0], cp[0]};
    always_ff @(posedge clk_i) begin
      par_q <= par_v[k];
    end
    assign corner_o[k] = rdata[par_q];
  end

  // Each bank is read at the address of the last corner whose parity matches, or of corner 0 if none does.
  for (genvar b = 0; b < 16; b++) begin : g_ram
    logic [AW-1:0] ra;
    always_comb begin
      ra = raddr_v[0];
      for (int k = 0; k < 16; k++) begin
        if (par_v[k] == 4'(b)) begin
          ra = raddr_v[k];
        end
      end
    end
    lqi_ram #(
      .Width (ValueBits),
      .Depth (BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_i && ({wr_i[0], wz_i[0], wd_i[0], wp_i[0]} == 4'(b))),
      .waddr_i (waddr),
      .wdata_i (wdata_i),
      .raddr_i (ra),
      .rdata_o (rdata[b])
    );
  end

endmodule
